// ===== rtl/vps_pkg.sv =====
// Shared types, constants and saturating arithmetic for the vorticity predictor stencil.
package vps_pkg;

  // Q23.40 word and register formats.
  localparam int WORD_W     = 64;
  localparam int FRAC_W     = 40;
  localparam int CFG_W      = 63;
  localparam int CFG_IDX_W  = 3;

  // Number of register stages from input transfer to output register.
  localparam int PIPE_DEPTH = 32;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP    = 3'd0,
    REG_INV_REYNOLDS = 3'd1,
    REG_INV_DX       = 3'd2,
    REG_INV_DY       = 3'd3,
    REG_DAMPING      = 3'd4,
    REG_RHS_SCALE    = 3'd5
  } cfg_reg_t;

  // Register values after reset.
  localparam cfg_word_t RST_TIME_STEP    = 63'd1099511628;
  localparam cfg_word_t RST_INV_REYNOLDS = 63'd10995116;
  localparam cfg_word_t RST_INV_DX       = 63'd21990232555520;
  localparam cfg_word_t RST_INV_DY       = 63'd21990232555520;
  localparam cfg_word_t RST_DAMPING      = 63'd219902325555;
  localparam cfg_word_t RST_RHS_SCALE    = 63'd687194767;

  localparam word_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t S64_MIN = 64'sh8000_0000_0000_0000;

  // Saturating sum.
  function automatic word_t s_add(input word_t a, input word_t b);
    logic [WORD_W:0] sum;
    sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (sum[WORD_W] != sum[WORD_W-1]) begin
      return sum[WORD_W] ? S64_MIN : S64_MAX;
    end
    return word_t'(sum[WORD_W-1:0]);
  endfunction

  // Saturating difference.
  function automatic word_t s_sub(input word_t a, input word_t b);
    logic [WORD_W:0] dif;
    dif = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (dif[WORD_W] != dif[WORD_W-1]) begin
      return dif[WORD_W] ? S64_MIN : S64_MAX;
    end
    return word_t'(dif[WORD_W-1:0]);
  endfunction

  // Saturating negation: only the most negative value clips.
  function automatic word_t s_neg(input word_t a);
    if (a == S64_MIN) begin
      return S64_MAX;
    end
    return -a;
  endfunction

  function automatic word_t s_abs(input word_t a);
    return a[WORD_W-1] ? s_neg(a) : a;
  endfunction

  // Saturating product with a small constant integer.
  function automatic word_t s_mulk(input word_t a, input logic [3:0] k);
    logic signed [WORD_W+4:0] prd;
    prd = a * $signed({1'b0, k});
    if (prd[WORD_W+4:WORD_W-1] != {6{prd[WORD_W-1]}}) begin
      return prd[WORD_W+4] ? S64_MIN : S64_MAX;
    end
    return word_t'(prd[WORD_W-1:0]);
  endfunction

endpackage

// ===== rtl/vps_if.sv =====
// Stream and configuration channel interfaces of the vorticity predictor stencil.
interface vps_in_if;
  logic             valid;
  logic             ready;
  vps_pkg::word_t   vort_center;
  vps_pkg::word_t   vort_east1;
  vps_pkg::word_t   vort_east2;
  vps_pkg::word_t   vort_west1;
  vps_pkg::word_t   vort_west2;
  vps_pkg::word_t   vort_north1;
  vps_pkg::word_t   vort_north2;
  vps_pkg::word_t   vort_south1;
  vps_pkg::word_t   vort_south2;
  vps_pkg::word_t   vel_x;
  vps_pkg::word_t   vel_y;
  vps_pkg::word_t   forcing;

  modport source (
    output valid, vort_center, vort_east1, vort_east2, vort_west1, vort_west2,
           vort_north1, vort_north2, vort_south1, vort_south2, vel_x, vel_y, forcing,
    input  ready
  );
  modport sink (
    input  valid, vort_center, vort_east1, vort_east2, vort_west1, vort_west2,
           vort_north1, vort_north2, vort_south1, vort_south2, vel_x, vel_y, forcing,
    output ready
  );
endinterface

interface vps_out_if;
  logic             valid;
  logic             ready;
  vps_pkg::word_t   new_vorticity;
  vps_pkg::word_t   poisson_rhs;

  modport source (output valid, new_vorticity, poisson_rhs, input ready);
  modport sink   (input valid, new_vorticity, poisson_rhs, output ready);
endinterface

interface vps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vps_pkg::CFG_IDX_W-1:0]    index;
  logic [vps_pkg::WORD_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vorticity_predictor_stencil.sv =====
// Top level: explicit vorticity update for one grid cell per transfer.
// From input transfer to result: advection 12 stages, sum 1, divide 6,
// tendency 3, time step 4, new value 2 and right-hand-side multiply 4.
// Throughput is one cell per cycle while the output is ready; every stage has its own
// valid bit and empty stages are filled while the output waits.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
module vorticity_predictor_stencil (
  input  logic      clk,
  input  logic      rst_n,
  vps_in_if.sink    in_ch,
  vps_out_if.source out_ch,
  vps_cfg_if.sink   cfg_ch
);
  import vps_pkg::*;

  cfg_word_t ts_r, ire_r, idx_r, idy_r, dmp_r, rs_r;
  word_t     ts_w, ire_w, idx_w, idy_w, dmp_w, rs_w;

  logic [PIPE_DEPTH:1] v_r;
  logic [PIPE_DEPTH:1] ce;

  word_t c_d     [1:26];
  word_t force_d [1:20];
  word_t dampc_d [5:21];
  word_t diff_d  [12:19];
  word_t nv_d    [28:32];
  word_t advx, advy, diffx, diffy, dampc, adv, dt, rhs;
  word_t adv_sum_r, diff_r, tend1_r, tend2_r, tend3_r, nv_r, ng_r;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= RST_TIME_STEP;
      ire_r <= RST_INV_REYNOLDS;
      idx_r <= RST_INV_DX;
      idy_r <= RST_INV_DY;
      dmp_r <= RST_DAMPING;
      rs_r  <= RST_RHS_SCALE;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_TIME_STEP:    ts_r  <= cfg_ch.data[CFG_W-1:0];
        REG_INV_REYNOLDS: ire_r <= cfg_ch.data[CFG_W-1:0];
        REG_INV_DX:       idx_r <= cfg_ch.data[CFG_W-1:0];
        REG_INV_DY:       idy_r <= cfg_ch.data[CFG_W-1:0];
        REG_DAMPING:      dmp_r <= cfg_ch.data[CFG_W-1:0];
        REG_RHS_SCALE:    rs_r  <= cfg_ch.data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign ts_w  = word_t'({1'b0, ts_r});
  assign ire_w = word_t'({1'b0, ire_r});
  assign idx_w = word_t'({1'b0, idx_r});
  assign idy_w = word_t'({1'b0, idy_r});
  assign dmp_w = word_t'({1'b0, dmp_r});
  assign rs_w  = word_t'({1'b0, rs_r});

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    ce[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || out_ch.ready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
  end

  assign in_ch.ready = ce[1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (ce[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Advection and diffusion along both axes.
  vps_adv_axis u_adv_x (
    .clk(clk), .ce(ce[12:1]), .c(in_ch.vort_center),
    .p1(in_ch.vort_east1), .p2(in_ch.vort_east2),
    .m1(in_ch.vort_west1), .m2(in_ch.vort_west2),
    .vel(in_ch.vel_x), .inv_d(idx_w), .adv(advx)
  );
  vps_adv_axis u_adv_y (
    .clk(clk), .ce(ce[12:1]), .c(in_ch.vort_center),
    .p1(in_ch.vort_north1), .p2(in_ch.vort_north2),
    .m1(in_ch.vort_south1), .m2(in_ch.vort_south2),
    .vel(in_ch.vel_y), .inv_d(idy_w), .adv(advy)
  );
  vps_diff_axis u_diff_x (
    .clk(clk), .ce(ce[10:1]), .c(in_ch.vort_center),
    .p1(in_ch.vort_east1), .m1(in_ch.vort_west1),
    .inv_d(idx_w), .inv_re(ire_w), .diff(diffx)
  );
  vps_diff_axis u_diff_y (
    .clk(clk), .ce(ce[10:1]), .c(in_ch.vort_center),
    .p1(in_ch.vort_north1), .m1(in_ch.vort_south1),
    .inv_d(idy_w), .inv_re(ire_w), .diff(diffy)
  );

  // Damping term on the old vorticity, stages one to four.
  vps_qmul u_damp (.clk(clk), .ce(ce[4:1]), .a(dmp_w), .b(in_ch.vort_center), .p(dampc));

  // Delay lines for operands used late in the pipeline.
  always_ff @(posedge clk) begin
    if (ce[1]) begin
      c_d[1]     <= in_ch.vort_center;
      force_d[1] <= in_ch.forcing;
    end
    for (int k = 2; k <= 26; k++) begin
      if (ce[k]) begin
        c_d[k] <= c_d[k-1];
      end
    end
    for (int k = 2; k <= 20; k++) begin
      if (ce[k]) begin
        force_d[k] <= force_d[k-1];
      end
    end
    if (ce[5]) begin
      dampc_d[5] <= dampc;
    end
    for (int k = 6; k <= 21; k++) begin
      if (ce[k]) begin
        dampc_d[k] <= dampc_d[k-1];
      end
    end
  end

  // Stage eleven: total diffusion, then carried to stage nineteen.
  always_ff @(posedge clk) begin
    if (ce[11]) begin
      diff_r <= s_add(diffx, diffy);
    end
    if (ce[12]) begin
      diff_d[12] <= diff_r;
    end
    for (int k = 13; k <= 19; k++) begin
      if (ce[k]) begin
        diff_d[k] <= diff_d[k-1];
      end
    end
  end

  // Stage thirteen: total advection; stages fourteen to nineteen divide by twelve.
  always_ff @(posedge clk) begin
    if (ce[13]) begin
      adv_sum_r <= s_add(advx, advy);
    end
  end

  vps_div12 u_div12 (.clk(clk), .ce(ce[19:14]), .x(adv_sum_r), .q(adv));

  // Stages twenty to twenty-two: tendency, one saturating step each.
  always_ff @(posedge clk) begin
    if (ce[20]) begin
      tend1_r <= s_sub(diff_d[19], adv);
    end
    if (ce[21]) begin
      tend2_r <= s_add(tend1_r, force_d[20]);
    end
    if (ce[22]) begin
      tend3_r <= s_sub(tend2_r, dampc_d[21]);
    end
  end

  // Stages twenty-three to twenty-six: tendency times time step.
  vps_qmul u_step (.clk(clk), .ce(ce[26:23]), .a(ts_w), .b(tend3_r), .p(dt));

  // Stages twenty-seven and twenty-eight: new vorticity and its negation.
  always_ff @(posedge clk) begin
    if (ce[27]) begin
      nv_r <= s_add(c_d[26], dt);
    end
    if (ce[28]) begin
      ng_r     <= s_neg(nv_r);
      nv_d[28] <= nv_r;
    end
    for (int k = 29; k <= 32; k++) begin
      if (ce[k]) begin
        nv_d[k] <= nv_d[k-1];
      end
    end
  end

  // Stages twenty-nine to thirty-two: Poisson right-hand side; last stage is the output.
  vps_qmul u_rhs (.clk(clk), .ce(ce[32:29]), .a(ng_r), .b(rs_w), .p(rhs));

  assign out_ch.valid         = v_r[PIPE_DEPTH];
  assign out_ch.new_vorticity = nv_d[32];
  assign out_ch.poisson_rhs   = rhs;

endmodule

// ===== rtl/vps_qmul.sv =====
// Four-stage pipelined Q23.40 multiplier with floor rounding and saturation.
module vps_qmul (
  input  logic           clk,
  input  logic [3:0]     ce,
  input  vps_pkg::word_t a,
  input  vps_pkg::word_t b,
  output vps_pkg::word_t p
);
  import vps_pkg::*;

  logic [WORD_W-1:0]   x_r, y_r;
  logic                neg_a_r, neg_b_r, neg_c_r;
  logic [WORD_W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [2*WORD_W-1:0] prod_r;
  logic [2*WORD_W-1:0] prod_nxt;
  word_t               p_r, p_nxt;
  logic                hi_ovf;
  logic                frac_nz;
  logic [WORD_W-1:0]   q;

  // Stage one: operand magnitudes and product sign.
  always_ff @(posedge clk) begin
    if (ce[0]) begin
      x_r     <= a[WORD_W-1] ? (~a + 64'd1) : a;
      y_r     <= b[WORD_W-1] ? (~b + 64'd1) : b;
      neg_a_r <= a[WORD_W-1] ^ b[WORD_W-1];
    end
  end

  // Stage two: four 32 by 32 partial products.
  always_ff @(posedge clk) begin
    if (ce[1]) begin
      ll_r    <= x_r[31:0]  * y_r[31:0];
      lh_r    <= x_r[31:0]  * y_r[63:32];
      hl_r    <= x_r[63:32] * y_r[31:0];
      hh_r    <= x_r[63:32] * y_r[63:32];
      neg_b_r <= neg_a_r;
    end
  end

  // Stage three: full 128-bit magnitude product.
  assign prod_nxt = {hh_r, ll_r} + (128'(lh_r) << 32) + (128'(hl_r) << 32);

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      prod_r  <= prod_nxt;
      neg_c_r <= neg_b_r;
    end
  end

  // Stage four: drop the fraction bits, round toward minus infinity and clip.
  always_comb begin
    hi_ovf  = |prod_r[2*WORD_W-1:WORD_W+FRAC_W];
    frac_nz = |prod_r[FRAC_W-1:0];
    q       = prod_r[WORD_W+FRAC_W-1:FRAC_W];
    if (hi_ovf) begin
      p_nxt = neg_c_r ? S64_MIN : S64_MAX;
    end else if (!neg_c_r) begin
      p_nxt = q[WORD_W-1] ? S64_MAX : word_t'(q);
    end else if (q[WORD_W-1]) begin
      p_nxt = S64_MIN;
    end else begin
      // A dropped nonzero fraction pushes the negative result one step down.
      p_nxt = frac_nz ? word_t'(~q) : word_t'(~q + 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[3]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/vps_div12.sv =====
// Six-stage pipelined signed division by twelve, rounding toward zero.
module vps_div12 (
  input  logic           clk,
  input  logic [5:0]     ce,
  input  vps_pkg::word_t x,
  output vps_pkg::word_t q
);
  import vps_pkg::*;

  localparam int         CHUNK_W    = 16;
  localparam int         NUM_CHUNKS = WORD_W / CHUNK_W;
  localparam logic [19:0] RECIP3    = 20'd349526;

  logic [WORD_W-1:0] w_r   [0:NUM_CHUNKS];
  logic [WORD_W-1:0] quo_r [0:NUM_CHUNKS];
  logic [1:0]        rem_r [0:NUM_CHUNKS];
  logic              neg_r [0:NUM_CHUNKS];
  logic [WORD_W-1:0] mag;
  word_t             q_r;

  // Magnitude divided by four; the rest is a division by three.
  assign mag = x[WORD_W-1] ? (~x + 64'd1) : x;

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      w_r[0]   <= {2'b00, mag[WORD_W-1:2]};
      quo_r[0] <= '0;
      rem_r[0] <= '0;
      neg_r[0] <= x[WORD_W-1];
    end
  end

  // Long division by three, one 16-bit digit per stage from the top.
  for (genvar k = 1; k <= NUM_CHUNKS; k++) begin : g_chunk
    logic [CHUNK_W+1:0]  val;
    logic [CHUNK_W+21:0] prd;
    logic [CHUNK_W-1:0]  qd;
    logic [1:0]          rm;
    logic [WORD_W-1:0]   quo_nxt;

    always_comb begin
      val     = {rem_r[k-1], w_r[k-1][WORD_W-1-CHUNK_W*(k-1) -: CHUNK_W]};
      prd     = val * RECIP3;
      qd      = prd[CHUNK_W+19:20];
      rm      = 2'(val - 18'(qd) * 18'd3);
      quo_nxt = quo_r[k-1];
      quo_nxt[WORD_W-1-CHUNK_W*(k-1) -: CHUNK_W] = qd;
    end

    always_ff @(posedge clk) begin
      if (ce[k]) begin
        w_r[k]   <= w_r[k-1];
        quo_r[k] <= quo_nxt;
        rem_r[k] <= rm;
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // Restore the sign of the dividend.
  always_ff @(posedge clk) begin
    if (ce[NUM_CHUNKS+1]) begin
      q_r <= neg_r[NUM_CHUNKS] ? word_t'(~quo_r[NUM_CHUNKS] + 64'd1)
                               : word_t'(quo_r[NUM_CHUNKS]);
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/vps_adv_axis.sv =====
// One axis of third-order upwind advection, twelve pipeline stages.
module vps_adv_axis (
  input  logic           clk,
  input  logic [12:1]    ce,
  input  vps_pkg::word_t c,
  input  vps_pkg::word_t p1,
  input  vps_pkg::word_t p2,
  input  vps_pkg::word_t m1,
  input  vps_pkg::word_t m2,
  input  vps_pkg::word_t vel,
  input  vps_pkg::word_t inv_d,
  output vps_pkg::word_t adv
);
  import vps_pkg::*;

  word_t a_r, b_r, spm_r, sp2_r, c6_r, av_r, vel1_r;
  word_t d1_r, v3_r, t_r, sp2b_r, vel2_r;
  word_t d4_r, d1b_r, v3b_r, vel3_r;
  word_t t1, t4, s_r;

  // Stage one: neighbor sums and differences, six times the center and the velocity magnitude.
  always_ff @(posedge clk) begin
    if (ce[1]) begin
      a_r    <= s_sub(m2, p2);
      b_r    <= s_sub(p1, m1);
      spm_r  <= s_add(p1, m1);
      sp2_r  <= s_add(p2, m2);
      c6_r   <= s_mulk(c, 4'd6);
      av_r   <= s_abs(vel);
      vel1_r <= vel;
    end
  end

  // Stage two: central difference and partial fourth difference.
  always_ff @(posedge clk) begin
    if (ce[2]) begin
      d1_r   <= s_add(a_r, s_mulk(b_r, 4'd8));
      v3_r   <= s_mulk(av_r, 4'd3);
      t_r    <= s_sub(c6_r, s_mulk(spm_r, 4'd4));
      sp2b_r <= sp2_r;
      vel2_r <= vel1_r;
    end
  end

  // Stage three: fourth difference complete.
  always_ff @(posedge clk) begin
    if (ce[3]) begin
      d4_r   <= s_add(sp2b_r, t_r);
      d1b_r  <= d1_r;
      v3b_r  <= v3_r;
      vel3_r <= vel2_r;
    end
  end

  // Stages four to seven: velocity and dissipation weights.
  vps_qmul u_t1 (.clk(clk), .ce(ce[7:4]), .a(vel3_r), .b(d1b_r), .p(t1));
  vps_qmul u_t4 (.clk(clk), .ce(ce[7:4]), .a(v3b_r),  .b(d4_r),  .p(t4));

  // Stage eight: combined flux term.
  always_ff @(posedge clk) begin
    if (ce[8]) begin
      s_r <= s_add(t1, t4);
    end
  end

  // Stages nine to twelve: scale by inverse grid spacing.
  vps_qmul u_scale (.clk(clk), .ce(ce[12:9]), .a(s_r), .b(inv_d), .p(adv));

endmodule

// ===== rtl/vps_diff_axis.sv =====
// One axis of second-order diffusion, ten pipeline stages.
module vps_diff_axis (
  input  logic           clk,
  input  logic [10:1]    ce,
  input  vps_pkg::word_t c,
  input  vps_pkg::word_t p1,
  input  vps_pkg::word_t m1,
  input  vps_pkg::word_t inv_d,
  input  vps_pkg::word_t inv_re,
  output vps_pkg::word_t diff
);
  import vps_pkg::*;

  word_t gpd_r, gmd_r;
  word_t gp, gm, ird, ird5_r, ird6_r, g_r;

  // Stage one: one-sided differences.
  always_ff @(posedge clk) begin
    if (ce[1]) begin
      gpd_r <= s_sub(p1, c);
      gmd_r <= s_sub(c, m1);
    end
  end

  // Stages two to five: gradients; stages one to four: viscosity over spacing.
  vps_qmul u_gp  (.clk(clk), .ce(ce[5:2]), .a(inv_d),  .b(gpd_r), .p(gp));
  vps_qmul u_gm  (.clk(clk), .ce(ce[5:2]), .a(inv_d),  .b(gmd_r), .p(gm));
  vps_qmul u_ird (.clk(clk), .ce(ce[4:1]), .a(inv_re), .b(inv_d), .p(ird));

  always_ff @(posedge clk) begin
    if (ce[5]) begin
      ird5_r <= ird;
    end
  end

  // Stage six: second difference.
  always_ff @(posedge clk) begin
    if (ce[6]) begin
      g_r    <= s_sub(gp, gm);
      ird6_r <= ird5_r;
    end
  end

  // Stages seven to ten: viscous scaling.
  vps_qmul u_diff (.clk(clk), .ce(ce[10:7]), .a(ird6_r), .b(g_r), .p(diff));

endmodule

// ===== rtl/vps_checker.sv =====
// Port-level assertions for the vorticity predictor stencil and their bind.
module vps_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input vps_pkg::word_t new_vorticity,
  input vps_pkg::word_t poisson_rhs
);
  import vps_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items inside the block: transfers in minus transfers out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A result that waits stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_vorticity) && $stable(poisson_rhs))
    else $error("waiting result changed or dropped");

  // No result without an item inside.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result with no item in flight");

  // While any stage is free the block takes input.
  a_room_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(PIPE_DEPTH) |-> in_ready)
    else $error("input refused with a free stage");

endmodule

bind vorticity_predictor_stencil vps_checker u_vps_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .new_vorticity(out_ch.new_vorticity),
  .poisson_rhs(out_ch.poisson_rhs)
);
